/* src/mf2_pkg.sv */
`default_nettype none
package mf2_pkg;

    localparam int DEF_MAX_RADIUS = 3;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W    = 8;
    localparam int CHANNELS = 3;
    localparam int PIX_BITS = PIX_W * CHANNELS;
    localparam int COORD_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int BIT_IDX_W  = $clog2(PIX_W);

    localparam logic [1:0] BM_ZERO      = 2'd0;
    localparam logic [1:0] BM_REPLICATE = 2'd1;
    localparam logic [1:0] BM_SHRINK    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BORDER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RD,
        ST_WR,
        ST_COUNT,
        ST_START,
        ST_WAIT,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

/* src/mf2_line_store.sv */
`default_nettype none
module mf2_line_store import mf2_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
    input  wire logic                aclk,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire logic [PIX_BITS-1:0] wdata,
    input  wire logic [AW-1:0]       raddr,
    output logic      [PIX_BITS-1:0] rdata
);

    logic [PIX_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/mf2_lane.sv */
`default_nettype none
module mf2_lane import mf2_pkg::*; #(
    parameter int N     = 49,
    parameter int CNT_W = 6
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [PIX_W-1:0] vals [N],
    input  wire logic [N-1:0]     valid,
    input  wire logic [CNT_W-1:0] rank,
    output logic                  done,
    output logic      [PIX_W-1:0] median
);

    // radix select: fix one bit of the median per match and decide phase pair, msb first
    logic                 busy_reg, busy_next;
    logic                 phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;
    logic [PIX_W-1:0]     prefix_reg, prefix_next;
    logic [PIX_W-1:0]     mask_reg, mask_next;
    logic [CNT_W-1:0]     rank_reg, rank_next;
    logic [N-1:0]         match_reg, match_next;
    logic [CNT_W-1:0]     cnt;

    assign cnt    = CNT_W'($countones(match_reg));
    assign done   = done_reg;
    assign median = prefix_reg;

    always_comb begin
        busy_next   = busy_reg;
        phase_next  = phase_reg;
        done_next   = 1'b0;
        bit_next    = bit_reg;
        prefix_next = prefix_reg;
        mask_next   = mask_reg;
        rank_next   = rank_reg;
        match_next  = match_reg;
        if (start) begin
            busy_next   = 1'b1;
            phase_next  = 1'b0;
            bit_next    = BIT_IDX_W'(PIX_W - 1);
            prefix_next = '0;
            mask_next   = '0;
            rank_next   = rank;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                for (int i = 0; i < N; i++) begin
                    match_next[i] = valid[i] && (((vals[i] ^ prefix_reg) & mask_reg) == '0)
                                    && !vals[i][bit_reg];
                end
                phase_next = 1'b1;
            end else begin
                if (rank_reg >= cnt) begin
                    prefix_next[bit_reg] = 1'b1;
                    rank_next = rank_reg - cnt;
                end
                mask_next[bit_reg] = 1'b1;
                phase_next = 1'b0;
                if (bit_reg == '0) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        bit_reg    <= bit_next;
        prefix_reg <= prefix_next;
        mask_reg   <= mask_next;
        rank_reg   <= rank_next;
        match_reg  <= match_next;
    end

endmodule
`default_nettype wire

/* src/median_filter_2d_border_modes.sv */
`default_nettype none
// Streaming 2-D median filter for raster-order RGB pixels.
// s_axis: one pixel per request, s_tdata = blue, green, red (8 bits each).
// m_axis: filtered pixels with their coordinates; m_tlast marks the last result
// caused by one input pixel, m_tuser marks the last pixel of the frame.
// cfg: register index and data; taken every cycle, write only while idle.
// An input pixel is stored into a line store of 2*MAX_RADIUS+1 row banks and
// may release 0 to (radius+1)^2 results (row ends and frame end give bursts).
// Each result then has the window cleared (ST_SETUP), is gathered column by
// column (one column read from all row banks per ST_RD, ST_WR pair), is ranked
// (ST_COUNT), starts the lanes (ST_START), runs radix selection in three
// parallel channel lanes (a match and a decide phase per bit, then a done flag)
// and is written into the output register (ST_OUT).
// s_tready is high only while idle; the last result may still wait for m_tready.
// When m_tready is low the finished result waits in the output register and
// the next result waits in the lanes.
// Reset clears the registers to zero padding, radius 2, 512 x 512, and the
// position to row 0, column 0; the line store is not cleared.
module median_filter_2d_border_modes import mf2_pkg::*; #(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,  // blue, green, red
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,  // out_row, out_column, median_blue,
                                                 // median_green, median_red, zero pad
    output logic                       m_tlast,  // last_of_run
    output logic                       m_tuser,  // frame_done
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int S     = 2 * MAX_RADIUS + 1;
    localparam int N     = S * S;
    localparam int BK    = $clog2(S);
    localparam int CNT_W = $clog2(N + 1);
    localparam int CX    = $clog2(MAX_WIDTH);
    localparam int CY    = $clog2(MAX_HEIGHT);
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CB    = $clog2(MAXD + 1) + 2;

    typedef logic signed [CB-1:0] coord_t;

    // configuration
    logic [1:0]            border_mode_reg;
    logic [1:0]            radius_reg;
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            border_mode_reg  <= BM_ZERO;
            radius_reg       <= 2'd2;
            image_width_reg  <= CFG_DATA_W'(512);
            image_height_reg <= CFG_DATA_W'(512);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BORDER_MODE:  border_mode_reg  <= cfg_data[1:0];
                REG_RADIUS:       radius_reg       <= cfg_data[1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    coord_t w_s, h_s, rad_s, rad2_s;
    logic [1:0] mode;

    always_comb begin
        if (image_width_reg == '0) begin
            w_s = coord_t'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            w_s = coord_t'(MAX_WIDTH);
        end else begin
            w_s = coord_t'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            h_s = coord_t'(1);
        end else if (32'(image_height_reg) > MAX_HEIGHT) begin
            h_s = coord_t'(MAX_HEIGHT);
        end else begin
            h_s = coord_t'(image_height_reg);
        end
        if (32'(radius_reg) > MAX_RADIUS) begin
            rad_s = coord_t'(MAX_RADIUS);
        end else begin
            rad_s = coord_t'(radius_reg);
        end
        rad2_s = rad_s + rad_s;
        mode = (border_mode_reg == BM_REPLICATE || border_mode_reg == BM_SHRINK) ?
               border_mode_reg : BM_ZERO;
    end

    // control and working registers
    state_t             state_reg, state_next;
    logic [CX-1:0]      in_col_reg, in_col_next;
    logic [CY-1:0]      in_row_reg, in_row_next;
    logic [BK-1:0]      in_bank_reg, in_bank_next;
    coord_t             ir_reg, ir_next;
    logic [BK-1:0]      bank_ir_reg, bank_ir_next;
    coord_t             r_reg, r_next, c_reg, c_next;
    coord_t             c0_reg, c0_next, r1_reg, r1_next, c1_reg, c1_next;
    logic [BK-1:0]      j_reg, j_next;
    logic [PIX_BITS-1:0] win_reg [S][S];
    logic [PIX_BITS-1:0] win_next [S][S];
    logic               win_valid_reg [S][S];
    logic               win_valid_next [S][S];
    logic [CNT_W-1:0]   rank_reg, rank_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [47:0]        m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;
    logic               m_tuser_reg, m_tuser_next;

    // line store banks
    logic                s_acc;
    logic [BK-1:0]       wr_bank;
    logic [CX-1:0]       wr_addr;
    logic [CX-1:0]       rd_addr;
    logic [PIX_BITS-1:0] rd_data [S];

    for (genvar b = 0; b < S; b++) begin : g_bank
        mf2_line_store #(
            .DEPTH (MAX_WIDTH),
            .AW    (CX)
        ) u_store (
            .aclk  (aclk),
            .we    (s_acc && (wr_bank == BK'(b))),
            .waddr (wr_addr),
            .wdata (s_tdata),
            .raddr (rd_addr),
            .rdata (rd_data[b])
        );
    end

    // channel lanes
    logic [N-1:0]       valid_flat;
    logic [PIX_W-1:0]   lane_vals [CHANNELS][N];
    logic               lane_start;
    logic [CHANNELS-1:0] lane_done;
    logic [PIX_W-1:0]   lane_med [CHANNELS];

    always_comb begin
        for (int k = 0; k < S; k++) begin
            for (int j = 0; j < S; j++) begin
                valid_flat[k * S + j] = win_valid_reg[k][j];
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    lane_vals[ch][k * S + j] = win_reg[k][j][ch * PIX_W +: PIX_W];
                end
            end
        end
    end

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        mf2_lane #(
            .N     (N),
            .CNT_W (CNT_W)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .vals    (lane_vals[ch]),
            .valid   (valid_flat),
            .rank    (rank_reg),
            .done    (lane_done[ch]),
            .median  (lane_med[ch])
        );
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // column of the window currently read
    coord_t x_s, xc_s;
    logic   in_x;

    always_comb begin
        x_s  = c_reg - rad_s + coord_t'(j_reg);
        in_x = (x_s >= 0) && (x_s < w_s);
        if (x_s < 0) begin
            xc_s = '0;
        end else if (x_s > w_s - coord_t'(1)) begin
            xc_s = w_s - coord_t'(1);
        end else begin
            xc_s = x_s;
        end
        rd_addr = xc_s[CX-1:0];
    end

    coord_t          col_pre, row_pre, col_post, row_post, r0_s, c0_s;
    logic [BK-1:0]   bank_pre, bank_post;
    coord_t          y_s, yc_s, b_s;
    logic            in_y, k_act;
    logic [PIX_BITS-1:0] px;
    logic            out_free;

    always_comb begin
        state_next    = state_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_bank_next  = in_bank_reg;
        ir_next       = ir_reg;
        bank_ir_next  = bank_ir_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        c0_next       = c0_reg;
        r1_next       = r1_reg;
        c1_next       = c1_reg;
        j_next        = j_reg;
        win_next      = win_reg;
        win_valid_next = win_valid_reg;
        rank_next     = rank_reg;
        lane_start    = 1'b0;
        out_free      = !m_tvalid_reg || m_tready;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        y_s  = '0;
        yc_s = '0;
        b_s  = '0;
        in_y = 1'b0;
        k_act = 1'b0;
        px   = '0;

        // position of the incoming pixel, wrapped to the current geometry
        col_pre  = coord_t'(in_col_reg);
        row_pre  = coord_t'(in_row_reg);
        bank_pre = in_bank_reg;
        if (col_pre >= w_s) begin
            col_pre  = '0;
            row_pre  = row_pre + coord_t'(1);
            bank_pre = (bank_pre == BK'(S - 1)) ? '0 : bank_pre + 1'b1;
        end
        if (row_pre >= h_s) begin
            row_pre  = '0;
            bank_pre = '0;
        end
        col_post  = col_pre + coord_t'(1);
        row_post  = row_pre;
        bank_post = bank_pre;
        if (col_post >= w_s) begin
            col_post  = '0;
            row_post  = row_pre + coord_t'(1);
            bank_post = (bank_pre == BK'(S - 1)) ? '0 : bank_pre + 1'b1;
            if (row_post >= h_s) begin
                row_post  = '0;
                bank_post = '0;
            end
        end
        wr_bank = bank_pre;
        wr_addr = col_pre[CX-1:0];

        if (row_pre == h_s - coord_t'(1)) begin
            r0_s = (h_s - coord_t'(1) - rad_s < 0) ? '0 : h_s - coord_t'(1) - rad_s;
            r1_next = h_s - coord_t'(1);
        end else begin
            r0_s = row_pre - rad_s;
            r1_next = r0_s;
        end
        if (col_pre == w_s - coord_t'(1)) begin
            c0_s = (w_s - coord_t'(1) - rad_s < 0) ? '0 : w_s - coord_t'(1) - rad_s;
            c1_next = w_s - coord_t'(1);
        end else begin
            c0_s = col_pre - rad_s;
            c1_next = c0_s;
        end

        case (state_reg)
            ST_IDLE: begin
                if (!s_acc) begin
                    r1_next = r1_reg;
                    c1_next = c1_reg;
                end else begin
                    in_col_next  = col_post[CX-1:0];
                    in_row_next  = row_post[CY-1:0];
                    in_bank_next = bank_post;
                    ir_next      = row_pre;
                    bank_ir_next = bank_pre;
                    r_next       = r0_s;
                    c_next       = c0_s;
                    c0_next      = c0_s;
                    if (r0_s >= 0 && c0_s >= 0) begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                r1_next = r1_reg;
                c1_next = c1_reg;
                for (int k = 0; k < S; k++) begin
                    for (int j = 0; j < S; j++) begin
                        win_valid_next[k][j] = 1'b0;
                    end
                end
                j_next = '0;
                state_next = ST_RD;
            end
            ST_RD: begin
                r1_next = r1_reg;
                c1_next = c1_reg;
                state_next = ST_WR;
            end
            ST_WR: begin
                r1_next = r1_reg;
                c1_next = c1_reg;
                for (int k = 0; k < S; k++) begin
                    y_s   = r_reg - rad_s + coord_t'(k);
                    in_y  = (y_s >= 0) && (y_s < h_s);
                    k_act = (coord_t'(k) <= rad2_s);
                    if (y_s < 0) begin
                        yc_s = '0;
                    end else if (y_s > h_s - coord_t'(1)) begin
                        yc_s = h_s - coord_t'(1);
                    end else begin
                        yc_s = y_s;
                    end
                    // rows at or above the newest row: bank = newest bank minus offset
                    b_s = coord_t'(bank_ir_reg) + yc_s - ir_reg;
                    if (b_s < 0) begin
                        b_s = b_s + coord_t'(S);
                    end
                    px = rd_data[b_s[BK-1:0]];
                    case (mode)
                        BM_SHRINK: begin
                            win_valid_next[k][j_reg] = k_act && in_y && in_x;
                            win_next[k][j_reg] = px;
                        end
                        BM_REPLICATE: begin
                            win_valid_next[k][j_reg] = k_act;
                            win_next[k][j_reg] = px;
                        end
                        default: begin
                            win_valid_next[k][j_reg] = k_act;
                            win_next[k][j_reg] = (in_y && in_x) ? px : '0;
                        end
                    endcase
                end
                if (coord_t'(j_reg) == rad2_s) begin
                    state_next = ST_COUNT;
                end else begin
                    j_next = j_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_COUNT: begin
                r1_next = r1_reg;
                c1_next = c1_reg;
                rank_next = CNT_W'($countones(valid_flat) >> 1);
                state_next = ST_START;
            end
            ST_START: begin
                r1_next = r1_reg;
                c1_next = c1_reg;
                lane_start = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                r1_next = r1_reg;
                c1_next = c1_reg;
                if (&lane_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                r1_next = r1_reg;
                c1_next = c1_reg;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next = {4'b0, lane_med[2], lane_med[1], lane_med[0],
                                    c_reg[COORD_W-1:0], r_reg[COORD_W-1:0]};
                    m_tlast_next = (r_reg == r1_reg) && (c_reg == c1_reg);
                    m_tuser_next = (r_reg == h_s - coord_t'(1)) && (c_reg == w_s - coord_t'(1));
                    if ((r_reg == r1_reg) && (c_reg == c1_reg)) begin
                        state_next = ST_IDLE;
                    end else if (c_reg == c1_reg) begin
                        c_next = c0_reg;
                        r_next = r_reg + coord_t'(1);
                        state_next = ST_SETUP;
                    end else begin
                        c_next = c_reg + coord_t'(1);
                        state_next = ST_SETUP;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_bank_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_bank_reg  <= in_bank_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        ir_reg        <= ir_next;
        bank_ir_reg   <= bank_ir_next;
        r_reg         <= r_next;
        c_reg         <= c_next;
        c0_reg        <= c0_next;
        r1_reg        <= r1_next;
        c1_reg        <= c1_next;
        j_reg         <= j_next;
        win_reg       <= win_next;
        win_valid_reg <= win_valid_next;
        rank_reg      <= rank_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
        m_tuser_reg   <= m_tuser_next;
    end

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import mf2_pkg::*;

    localparam int STORE_ROWS = 2 * DEF_MAX_RADIUS + 1;
    localparam logic [1:0] BM_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
        logic       done;
    } filtered_px_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic m_tlast;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    median_filter_2d_border_modes dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // filter state mirrored from the block
    logic [23:0] pixel_store [0:STORE_ROWS*DEF_MAX_WIDTH-1];
    int unsigned pos_row, pos_col;
    logic [1:0]  border_sel;
    logic [1:0]  win_radius;
    logic [10:0] frame_width, frame_height;

    filtered_px_t pending_px[$];
    int mismatches = 0;
    int failures = 0;
    int idle_cycles = 0;
    int random_pixels = 0;
    int burst_left = 0;
    bit hold_request = 0;

    function automatic logic [7:0] rank_middle(logic [7:0] v[$]);
        logic [7:0] t;
        int j;
        if (v.size() == 0) return 8'd0;
        for (int i = 1; i < v.size(); i++) begin
            t = v[i];
            j = i;
            while (j > 0 && v[j-1] > t) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = t;
        end
        return v[v.size()/2];
    endfunction

    function automatic filtered_px_t window_median(int r, int c, int rad, int w, int h);
        logic [7:0] vb[$], vg[$], vr[$];
        logic [23:0] px;
        filtered_px_t res;
        int y, x;
        bit in_image;
        for (int dy = -rad; dy <= rad; dy++) begin
            for (int dx = -rad; dx <= rad; dx++) begin
                y = r + dy;
                x = c + dx;
                in_image = (y >= 0 && y < h && x >= 0 && x < w);
                if (border_sel == BM_SHRINK) begin
                    if (!in_image) continue;
                    px = pixel_store[(y % STORE_ROWS) * DEF_MAX_WIDTH + x];
                end else if (border_sel == BM_REPLICATE) begin
                    if (y < 0) y = 0;
                    if (y > h - 1) y = h - 1;
                    if (x < 0) x = 0;
                    if (x > w - 1) x = w - 1;
                    px = pixel_store[(y % STORE_ROWS) * DEF_MAX_WIDTH + x];
                end else begin
                    px = in_image ? pixel_store[(y % STORE_ROWS) * DEF_MAX_WIDTH + x] : 24'd0;
                end
                vb.push_back(px[7:0]);
                vg.push_back(px[15:8]);
                vr.push_back(px[23:16]);
            end
        end
        res.row = r[9:0];
        res.col = c[9:0];
        res.blue = rank_middle(vb);
        res.green = rank_middle(vg);
        res.red = rank_middle(vr);
        res.last = 1'b0;
        res.done = (r == h - 1 && c == w - 1);
        return res;
    endfunction

    function automatic void predict_pixel(logic [23:0] pix);
        int w, h, rad, ir, ic, r0, r1, c0, c1;
        w = (frame_width == 0) ? 1 : (frame_width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : frame_width);
        h = (frame_height == 0) ? 1 :
            (frame_height > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : frame_height);
        rad = win_radius;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) pos_row = 0;
        ir = pos_row;
        ic = pos_col;
        pixel_store[(pos_row % STORE_ROWS) * DEF_MAX_WIDTH + pos_col] = pix;
        if (ir == h - 1) begin
            r0 = (h - 1 - rad < 0) ? 0 : h - 1 - rad;
            r1 = h - 1;
        end else begin
            r0 = ir - rad;
            r1 = r0;
        end
        if (ic == w - 1) begin
            c0 = (w - 1 - rad < 0) ? 0 : w - 1 - rad;
            c1 = w - 1;
        end else begin
            c0 = ic - rad;
            c1 = c0;
        end
        if (r0 >= 0 && c0 >= 0) begin
            for (int r = r0; r <= r1; r++)
                for (int c = c0; c <= c1; c++)
                    pending_px.push_back(window_median(r, c, rad, w, h));
            pending_px[pending_px.size() - 1].last = 1'b1;
        end
        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h) pos_row = 0;
        end
    endfunction

    // check results and watch for a hang; all outputs are stable at the falling edge
    always @(negedge aclk) begin
        filtered_px_t exp_px;
        logic [47:0] exp_data;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (pending_px.size() == 0) begin
                    failures++;
                    if (mismatches < 10)
                        $display("unexpected result: data %h last %b user %b",
                                 m_tdata, m_tlast, m_tuser);
                    mismatches++;
                end else begin
                    exp_px = pending_px.pop_front();
                    exp_data = {4'd0, exp_px.red, exp_px.green, exp_px.blue,
                                exp_px.col, exp_px.row};
                    if (m_tdata[9:0] !== exp_px.row || m_tdata[19:10] !== exp_px.col ||
                        m_tdata[27:20] !== exp_px.blue || m_tdata[35:28] !== exp_px.green ||
                        m_tdata[43:36] !== exp_px.red || m_tdata[47:44] !== 4'd0 ||
                        m_tlast !== exp_px.last || m_tuser !== exp_px.done) begin
                        failures++;
                        if (mismatches < 10)
                            $display("mismatch: expected data %h last %b user %b, got %h %b %b",
                                     exp_data, exp_px.last, exp_px.done,
                                     m_tdata, m_tlast, m_tuser);
                        mismatches++;
                    end
                end
            end
        end
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    always @(posedge aclk) begin
        static int hold_left = 0;
        static int pattern = 0;
        static int pattern_left = 0;
        if (hold_request) begin
            hold_left = 400;
            hold_request = 0;
        end
        if (pattern_left == 0) begin
            pattern = $urandom_range(0, 3);
            pattern_left = $urandom_range(20, 300);
        end
        pattern_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (pattern)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                2: m_tready <= (pattern_left % 8 < 3);
                default: m_tready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    task automatic send_pixel(logic [23:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        predict_pixel(pix);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        case (idx)
            REG_BORDER_MODE: border_sel = val[1:0];
            REG_RADIUS:      win_radius = val[1:0];
            REG_IMAGE_WIDTH: frame_width = val;
            default:         frame_height = val;
        endcase
    endtask

    task automatic set_geometry(logic [1:0] mode, logic [1:0] rad,
                                logic [10:0] w, logic [10:0] h);
        wait_quiet();
        write_reg(REG_BORDER_MODE, {9'd0, mode});
        write_reg(REG_RADIUS, {9'd0, rad});
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // pattern 0 random, 1 alternating black and white, 2 random extremes per channel
    task automatic send_frame(int npix, int pattern);
        logic [23:0] pix;
        for (int i = 0; i < npix; i++) begin
            case (pattern)
                0: pix = 24'($urandom);
                1: pix = i[0] ? 24'hFFFFFF : 24'h000000;
                default: pix = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                                {8{$urandom_range(0, 1) == 1}}};
            endcase
            send_pixel(pix);
        end
    endtask

    task automatic test_single_pixel_frames();
        // zero sizes act as one; radius 3 windows over a single pixel, then radius 0 with the unused mode code
        set_geometry(BM_ZERO, 2'd3, 11'd0, 11'd1);
        send_frame(1, 1);
        set_geometry(BM_REPLICATE, 2'd3, 11'd1, 11'd0);
        send_pixel(24'hFFFFFF);
        set_geometry(BM_SHRINK, 2'd3, 11'd1, 11'd1);
        send_pixel(24'h00FF00);
        set_geometry(BM_UNUSED, 2'd0, 11'd1, 11'd1);
        send_pixel(24'hFF00FF);
    endtask

    task automatic test_border_modes();
        set_geometry(BM_REPLICATE, 2'd1, 11'd3, 11'd3);
        send_frame(9, 1);
        set_geometry(BM_SHRINK, 2'd3, 11'd4, 11'd3);
        send_frame(12, 2);
    endtask

    task automatic test_wide_rows();
        // long rows with the largest window, bursts at last-row pixels from column 3 on
        set_geometry(2'($urandom_range(0, 3)), 2'd3, 11'd60, 11'd2);
        send_frame(120, 0);
    endtask

    task automatic test_random_frames();
        int w, h;
        while (random_pixels < 180) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            set_geometry(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), w[10:0], h[10:0]);
            send_frame(w * h, ($urandom_range(0, 4) == 0) ? 2 : 0);
            random_pixels += w * h;
        end
    endtask

    task automatic test_output_backpressure();
        set_geometry(BM_ZERO, 2'd3, 11'd8, 11'd8);
        hold_request = 1;
        send_frame(64, 0);
    endtask

    initial begin
        for (int i = 0; i < STORE_ROWS * DEF_MAX_WIDTH; i++) pixel_store[i] = '0;
        pos_row = 0;
        pos_col = 0;
        border_sel = BM_ZERO;
        win_radius = 2'd2;
        frame_width = 11'd512;
        frame_height = 11'd512;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_pixel_frames();
        test_border_modes();
        test_random_frames();
        test_output_backpressure();
        test_wide_rows();
        wait_quiet();
        if (pending_px.size() != 0) failures++;
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
